@@ rtl/shear_to_pvel_density_polynomial_defines.svh @@
// assertion macros for the shear to pvel density polynomial block
`ifndef SHEAR_TO_PVEL_DENSITY_POLYNOMIAL_DEFINES_SVH
`define SHEAR_TO_PVEL_DENSITY_POLYNOMIAL_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge
`define SPDP_ASSERT_NOW(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("spdp assertion failed");

// next-cycle implication, checked at every rising clock edge
`define SPDP_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("spdp assertion failed");

`endif

@@ rtl/spdp_pkg.sv @@
// shared types, widths and polynomial coefficients for the vs to vp/density pipeline
package spdp_pkg;

    // field and datapath widths
    localparam int SPEED_W   = 19;
    localparam int OUT_W     = 24;
    localparam int OPD_W     = 24;
    localparam int ACC_W     = 41;
    localparam int PROD_W    = ACC_W + OPD_W;
    localparam int WORK_FRAC = 28;

    // accumulator clamp, +/- 2^39
    localparam int ACC_LIM_LOG2 = 39;

    // output saturation limits
    localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN = -(1 << (OUT_W - 1));

    // coefficient counts, highest power first
    localparam int VP_N   = 5;
    localparam int DVP_N  = 4;
    localparam int RHO_N  = 6;
    localparam int DRHO_N = 5;

    // q28 coefficients, highest power first
    localparam logic signed [ACC_W-1:0] VP_COEF [VP_N] = '{
        ACC_W'(-6737730), ACC_W'(72021233), ACC_W'(-220278135),
        ACC_W'(562291750), ACC_W'(252570921)
    };
    localparam logic signed [ACC_W-1:0] DVP_COEF [DVP_N] = '{
        ACC_W'(-26950920), ACC_W'(216063699), ACC_W'(-440556270),
        ACC_W'(562291750)
    };
    localparam logic signed [ACC_W-1:0] RHO_COEF [RHO_N] = '{
        ACC_W'(28454), ACC_W'(-1154272), ACC_W'(18012019),
        ACC_W'(-126728379), ACC_W'(445924980), ACC_W'(0)
    };
    localparam logic signed [ACC_W-1:0] DRHO_COEF [DRHO_N] = '{
        ACC_W'(142271), ACC_W'(-4617090), ACC_W'(54036057),
        ACC_W'(-253456758), ACC_W'(445924980)
    };

    // control that travels with each transaction through the stages
    typedef struct packed {
        logic valid;
        logic clip;
    } spdp_ctl_t;

endpackage

@@ rtl/spdp_horner_step.sv @@
// one horner step: registered multiply, then round, add coefficient and clamp
module spdp_horner_step #(
    parameter int F = 16,
    parameter logic signed [spdp_pkg::ACC_W-1:0] COEF = '0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  spdp_pkg::spdp_ctl_t                 ctl_in,
    input  logic signed [spdp_pkg::OPD_W-1:0]   v_in,
    input  logic signed [spdp_pkg::ACC_W-1:0]   acc_in,
    output spdp_pkg::spdp_ctl_t                 ctl_out,
    output logic signed [spdp_pkg::OPD_W-1:0]   v_out,
    output logic signed [spdp_pkg::ACC_W-1:0]   acc_out
);
    import spdp_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(1) <<< (F - 1);
    localparam logic signed [PROD_W-1:0] LIM_POS = PROD_W'(1) <<< ACC_LIM_LOG2;
    localparam logic signed [PROD_W-1:0] LIM_NEG = -LIM_POS;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [OPD_W-1:0]  v_m_reg, v_a_reg;
    spdp_ctl_t                ctl_m_reg, ctl_a_reg, ctl_a_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] rnd, sum;
    logic                     hit;

    // multiply stage
    always_comb begin
        prod_next = PROD_W'(acc_in) * PROD_W'(v_in);
    end

    // round, add coefficient, clamp to the accumulator range
    always_comb begin
        rnd = (prod_reg + HALF) >>> F;
        sum = rnd + PROD_W'(COEF);
        hit = 1'b0;
        if (sum > LIM_POS) begin
            acc_next = ACC_W'(LIM_POS);
            hit      = 1'b1;
        end else if (sum < LIM_NEG) begin
            acc_next = ACC_W'(LIM_NEG);
            hit      = 1'b1;
        end else begin
            acc_next = ACC_W'(sum);
        end
        ctl_a_next = '{valid: ctl_m_reg.valid, clip: ctl_m_reg.clip | hit};
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_m_reg <= '0;
            ctl_a_reg <= '0;
        end else if (en) begin
            ctl_m_reg <= ctl_in;
            ctl_a_reg <= ctl_a_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            v_m_reg  <= v_in;
            acc_reg  <= acc_next;
            v_a_reg  <= v_m_reg;
        end
    end

    assign ctl_out = ctl_a_reg;
    assign v_out   = v_a_reg;
    assign acc_out = acc_reg;

endmodule

@@ rtl/spdp_round_sat.sv @@
// rounding right shift and saturation to the 24-bit output range
module spdp_round_sat #(
    parameter int IN_W  = 41,
    parameter int SHIFT = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  spdp_pkg::spdp_ctl_t                 ctl_in,
    input  logic signed [IN_W-1:0]              val_in,
    output spdp_pkg::spdp_ctl_t                 ctl_out,
    output logic signed [spdp_pkg::OUT_W-1:0]   q_out
);
    import spdp_pkg::*;

    localparam int EXT_W = IN_W + 1;
    localparam logic signed [EXT_W-1:0] HALF = EXT_W'(1) <<< (SHIFT - 1);
    localparam logic signed [EXT_W-1:0] HI   = EXT_W'(OUT_MAX);
    localparam logic signed [EXT_W-1:0] LO   = EXT_W'(OUT_MIN);

    logic signed [EXT_W-1:0] rnd;
    logic signed [OUT_W-1:0] q_reg, q_next;
    spdp_ctl_t               ctl_reg, ctl_next;
    logic                    hit;

    // round half up, then clip
    always_comb begin
        rnd = (EXT_W'(val_in) + HALF) >>> SHIFT;
        hit = 1'b0;
        if (rnd > HI) begin
            q_next = OUT_W'(HI);
            hit    = 1'b1;
        end else if (rnd < LO) begin
            q_next = OUT_W'(LO);
            hit    = 1'b1;
        end else begin
            q_next = OUT_W'(rnd);
        end
        ctl_next = '{valid: ctl_in.valid, clip: ctl_in.clip | hit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign q_out   = q_reg;

endmodule

@@ rtl/spdp_delay.sv @@
// stall-aware delay line that keeps side values aligned with the main pipeline
module spdp_delay #(
    parameter int DEPTH = 1,
    parameter int W     = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d_in,
    output logic [W-1:0] d_out
);
    logic [W-1:0] pipe_reg [DEPTH];

    // shift one place per advancing cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d_in;
            for (int i = 1; i < DEPTH; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign d_out = pipe_reg[DEPTH-1];

endmodule

@@ rtl/shear_to_pvel_density_polynomial.sv @@
// top level: shear velocity to pwave velocity, density and their slopes
// throughput: one transaction per cycle unless the result side stalls; each
// horner step is a multiply stage and a round/add/clamp stage, the density
// stages wait for the rounded vp
// a stall on the result side freezes every stage, nothing is lost or repeated
// reset (synchronous, active low) clears all valid bits; no clearing pass
`include "shear_to_pvel_density_polynomial_defines.svh"

module shear_to_pvel_density_polynomial #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [spdp_pkg::SPEED_W-1:0]          s_shear_speed,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [spdp_pkg::OUT_W-1:0]     m_pwave_speed,
    output logic signed [spdp_pkg::OUT_W-1:0]     m_density,
    output logic signed [spdp_pkg::OUT_W-1:0]     m_pwave_slope,
    output logic signed [spdp_pkg::OUT_W-1:0]     m_density_slope,
    output logic                                  m_saturated
);
    import spdp_pkg::*;

    localparam int OUT_SHIFT = WORK_FRAC - FRAC_BITS;
    localparam int SIDE_W    = OUT_W + 1;

    logic en;

    spdp_ctl_t               vp_ctl [VP_N];
    logic signed [OPD_W-1:0] vp_v   [VP_N];
    logic signed [ACC_W-1:0] vp_acc [VP_N];

    spdp_ctl_t               dvp_ctl [DVP_N];
    logic signed [OPD_W-1:0] dvp_v   [DVP_N];
    logic signed [ACC_W-1:0] dvp_acc [DVP_N];

    spdp_ctl_t               rho_ctl [RHO_N];
    logic signed [OPD_W-1:0] rho_v   [RHO_N];
    logic signed [ACC_W-1:0] rho_acc [RHO_N];

    spdp_ctl_t               drdv_ctl [DRHO_N];
    logic signed [OPD_W-1:0] drdv_v   [DRHO_N];
    logic signed [ACC_W-1:0] drdv_acc [DRHO_N];

    spdp_ctl_t               vp_q_ctl, dvp_q_ctl, rho_q_ctl, drho_q_ctl;
    logic signed [OUT_W-1:0] vp_q, dvp_q, rho_q, drho_q;

    logic [SIDE_W-1:0]       dvp_mid, drho_late;
    logic [OUT_W-1:0]        vp_late, dvp_late;
    logic signed [OUT_W-1:0] dvp_mid_q;

    logic signed [PROD_W-1:0] fin_prod_reg, fin_prod_next;
    spdp_ctl_t                fin_ctl_reg, fin_ctl_next;

    // whole pipeline advances unless a finished result is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // vp and dvp/dvs chains on the shear speed
    assign vp_ctl[0]  = '{valid: s_valid, clip: 1'b0};
    assign vp_v[0]    = OPD_W'(s_shear_speed);
    assign vp_acc[0]  = VP_COEF[0];
    assign dvp_ctl[0] = '{valid: s_valid, clip: 1'b0};
    assign dvp_v[0]   = OPD_W'(s_shear_speed);
    assign dvp_acc[0] = DVP_COEF[0];

    for (genvar i = 0; i < VP_N - 1; i++) begin : g_vp
        spdp_horner_step #(.F(FRAC_BITS), .COEF(VP_COEF[i+1])) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (vp_ctl[i]),
            .v_in    (vp_v[i]),
            .acc_in  (vp_acc[i]),
            .ctl_out (vp_ctl[i+1]),
            .v_out   (vp_v[i+1]),
            .acc_out (vp_acc[i+1])
        );
    end

    for (genvar i = 0; i < DVP_N - 1; i++) begin : g_dvp
        spdp_horner_step #(.F(FRAC_BITS), .COEF(DVP_COEF[i+1])) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (dvp_ctl[i]),
            .v_in    (dvp_v[i]),
            .acc_in  (dvp_acc[i]),
            .ctl_out (dvp_ctl[i+1]),
            .v_out   (dvp_v[i+1]),
            .acc_out (dvp_acc[i+1])
        );
    end

    // q28 to output format
    spdp_round_sat #(.IN_W(ACC_W), .SHIFT(OUT_SHIFT)) u_vp_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (vp_ctl[VP_N-1]),
        .val_in  (vp_acc[VP_N-1]),
        .ctl_out (vp_q_ctl),
        .q_out   (vp_q)
    );

    spdp_round_sat #(.IN_W(ACC_W), .SHIFT(OUT_SHIFT)) u_dvp_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (dvp_ctl[DVP_N-1]),
        .val_in  (dvp_acc[DVP_N-1]),
        .ctl_out (dvp_q_ctl),
        .q_out   (dvp_q)
    );

    // density and drho/dvp chains on the saturated vp
    assign rho_ctl[0]  = vp_q_ctl;
    assign rho_v[0]    = vp_q;
    assign rho_acc[0]  = RHO_COEF[0];
    assign drdv_ctl[0] = '{valid: vp_q_ctl.valid, clip: 1'b0};
    assign drdv_v[0]   = vp_q;
    assign drdv_acc[0] = DRHO_COEF[0];

    for (genvar i = 0; i < RHO_N - 1; i++) begin : g_rho
        spdp_horner_step #(.F(FRAC_BITS), .COEF(RHO_COEF[i+1])) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (rho_ctl[i]),
            .v_in    (rho_v[i]),
            .acc_in  (rho_acc[i]),
            .ctl_out (rho_ctl[i+1]),
            .v_out   (rho_v[i+1]),
            .acc_out (rho_acc[i+1])
        );
    end

    for (genvar i = 0; i < DRHO_N - 1; i++) begin : g_drdv
        spdp_horner_step #(.F(FRAC_BITS), .COEF(DRHO_COEF[i+1])) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (drdv_ctl[i]),
            .v_in    (drdv_v[i]),
            .acc_in  (drdv_acc[i]),
            .ctl_out (drdv_ctl[i+1]),
            .v_out   (drdv_v[i+1]),
            .acc_out (drdv_acc[i+1])
        );
    end

    spdp_round_sat #(.IN_W(ACC_W), .SHIFT(OUT_SHIFT)) u_rho_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (rho_ctl[RHO_N-1]),
        .val_in  (rho_acc[RHO_N-1]),
        .ctl_out (rho_q_ctl),
        .q_out   (rho_q)
    );

    // dvp/dvs waits for drho/dvp, then for the output stage
    spdp_delay #(.DEPTH(2 * (VP_N - DVP_N) + 2 * (DRHO_N - 1)), .W(SIDE_W)) u_dvp_mid (
        .aclk  (aclk),
        .en    (en),
        .d_in  ({dvp_q_ctl.clip, dvp_q}),
        .d_out (dvp_mid)
    );

    assign dvp_mid_q = dvp_mid[OUT_W-1:0];

    spdp_delay #(.DEPTH(2 * (RHO_N - DRHO_N) + 1), .W(OUT_W)) u_dvp_late (
        .aclk  (aclk),
        .en    (en),
        .d_in  (dvp_mid[OUT_W-1:0]),
        .d_out (dvp_late)
    );

    // chain rule product
    always_comb begin
        fin_prod_next = PROD_W'(drdv_acc[DRHO_N-1]) * PROD_W'(dvp_mid_q);
        fin_ctl_next  = '{valid: drdv_ctl[DRHO_N-1].valid,
                          clip:  drdv_ctl[DRHO_N-1].clip | dvp_mid[OUT_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_ctl_reg <= '0;
        end else if (en) begin
            fin_ctl_reg <= fin_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_prod_reg <= fin_prod_next;
        end
    end

    spdp_round_sat #(.IN_W(PROD_W), .SHIFT(WORK_FRAC)) u_drho_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (fin_ctl_reg),
        .val_in  (fin_prod_reg),
        .ctl_out (drho_q_ctl),
        .q_out   (drho_q)
    );

    spdp_delay #(.DEPTH(2 * (RHO_N - DRHO_N) - 1), .W(SIDE_W)) u_drho_late (
        .aclk  (aclk),
        .en    (en),
        .d_in  ({drho_q_ctl.clip, drho_q}),
        .d_out (drho_late)
    );

    // vp waits for the density chain
    spdp_delay #(.DEPTH(2 * (RHO_N - 1) + 1), .W(OUT_W)) u_vp_late (
        .aclk  (aclk),
        .en    (en),
        .d_in  (vp_q),
        .d_out (vp_late)
    );

    // result transaction
    assign m_valid         = rho_q_ctl.valid;
    assign m_pwave_speed   = vp_late;
    assign m_density       = rho_q;
    assign m_pwave_slope   = dvp_late;
    assign m_density_slope = drho_late[OUT_W-1:0];
    assign m_saturated     = rho_q_ctl.clip | drho_late[OUT_W];

    // a held result freezes the input side
    `SPDP_ASSERT_NOW(a_stall_blocks_input, aclk, m_valid && !m_ready, !s_ready)
    // an empty output stage never blocks the input side
    `SPDP_ASSERT_NOW(a_empty_takes_input, aclk, !m_valid, s_ready)
    // reset empties the result stage
    `SPDP_ASSERT_NEXT(a_reset_clears_out, aclk, !aresetn, !m_valid)

endmodule
